// File: rtl/fspf_pkg.sv
// Shared constants and types for the frame subnet payload filter.
// Holds protocol field offsets, register indexes and reset values.
// No dependencies; the top level refers to it by scoped names and the testbench imports it.
package fspf_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_COUNTER_ENTRIES = 256;
  localparam int DEF_COUNT_WIDTH     = 32;
  localparam int DEF_MAX_FRAME_BYTES = 16384;

  // Width used for all in-frame position arithmetic.
  localparam int POS_W = 16;
  // Width of the counter value field on the result channel.
  localparam int OUT_VALUE_W = 32;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_PREFIX    = 2'd0;
  localparam logic [1:0] CFG_MATCH_BYTE      = 2'd1;
  localparam logic [1:0] CFG_MATCH_OFFSET    = 2'd2;
  localparam logic [1:0] CFG_MIN_PAYLOAD_LEN = 2'd3;

  // Configuration reset values.
  localparam logic [23:0] RST_BLOCK_PREFIX    = 24'h32A8C0;
  localparam logic [7:0]  RST_MATCH_BYTE      = 8'h58;
  localparam logic [7:0]  RST_MATCH_OFFSET    = 8'd1;
  localparam logic [15:0] RST_MIN_PAYLOAD_LEN = 16'd7;

  // Ethernet and VLAN framing.
  localparam logic [4:0]  ETH_HDR_LEN   = 5'd14;
  localparam logic [4:0]  VLAN_TAG_LEN  = 5'd4;
  localparam logic [1:0]  MAX_VLAN_TAGS = 2'd2;
  localparam logic [15:0] ETYPE_VLAN_C  = 16'h8100;
  localparam logic [15:0] ETYPE_VLAN_S  = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;

  // Offsets inside the IP headers, relative to the network header start.
  localparam logic [POS_W-1:0] IP_OFF_VER_IHL  = 16'd0;
  localparam logic [POS_W-1:0] IP_OFF_TLEN_HI  = 16'd2;
  localparam logic [POS_W-1:0] IP_OFF_TLEN_LO  = 16'd3;
  localparam logic [POS_W-1:0] IP6_OFF_NEXT    = 16'd6;
  localparam logic [POS_W-1:0] IP_OFF_PROTO    = 16'd9;
  localparam logic [POS_W-1:0] IP_OFF_DST0     = 16'd16;
  localparam logic [POS_W-1:0] IP_OFF_DST1     = 16'd17;
  localparam logic [POS_W-1:0] IP_OFF_DST2     = 16'd18;
  localparam logic [POS_W-1:0] IPV4_HDR_LEN    = 16'd20;
  localparam logic [POS_W-1:0] IPV6_HDR_LEN    = 16'd40;
  localparam logic [7:0]       IPPROTO_TCP     = 8'd6;

  // TCP header: data offset byte position and minimum header length.
  localparam logic [POS_W-1:0] TCP_OFF_DOFF = 16'd12;
  localparam logic [POS_W-1:0] TCP_HDR_LEN  = 16'd20;
  // TCP header bytes kept ahead of the data offset byte.
  localparam int TCP_EARLY_BYTES = 12;
  localparam int TCP_EARLY_IW    = $clog2(TCP_EARLY_BYTES);

  // Everything the verdict logic needs about one finished frame.
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [4:0]       nh;
    logic [15:0]      etype;
    logic [3:0]       ihl;
    logic [3:0]       doff;
    logic [15:0]      tot_len;
    logic [7:0]       proto;
    logic [23:0]      prefix;
    logic [7:0]       v6_next;
    logic             pay_seen;
    logic             pay_hit;
  } frm_info_t;

endpackage

// File: rtl/fspf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the drop counter store. No dependencies.
module fspf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/frame_subnet_payload_filter_top.sv
// Top level of the frame subnet payload filter: byte parser, verdict stage
// and saturating drop counters. Depends on fspf_pkg and fspf_ram.
//
// Usage:
// Frame bytes enter on the in_ channel, one item per byte in wire order, with
// in_last_byte marking the final byte. The parser takes one byte per cycle and
// keeps only the header fields that the verdict needs. Each frame yields
// exactly one result item on the out_ channel: verdict, counted flag, counter
// index and the counter value after its saturating increment.
// The final byte's frame passes through the verdict stage register, then the
// counter stage register, then the output register. Throughput: one byte per
// cycle while in_stall is low, including back-to-back one-byte frames; the
// counter read-modify-write path forwards the previous write so consecutive
// hits on the same counter need no bubble.
// When out_stall is held, up to two more finished frames queue in the verdict
// and counter stages; after that in_stall rises and the parser holds.
// Reset (synchronous, rst_n low) returns the configuration registers to their
// defaults, empties the pipeline and clears every drop counter at once through
// per-entry valid bits, so no clearing pass is needed.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while idle.
module frame_subnet_payload_filter_top #(
  parameter int COUNTER_ENTRIES = fspf_pkg::DEF_COUNTER_ENTRIES,
  parameter int COUNT_WIDTH     = fspf_pkg::DEF_COUNT_WIDTH,
  parameter int MAX_FRAME_BYTES = fspf_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // Frame byte channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // Verdict channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_verdict,
  output logic        out_counted,
  output logic [7:0]  out_counter_index,
  output logic [31:0] out_counter_value,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int POS_W = fspf_pkg::POS_W;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(COUNTER_ENTRIES);
  localparam int EXT_W = (COUNT_WIDTH > fspf_pkg::OUT_VALUE_W) ?
                         COUNT_WIDTH : fspf_pkg::OUT_VALUE_W;
  localparam int EIW   = fspf_pkg::TCP_EARLY_IW;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [23:0] cfg_prefix_r;
  logic [7:0]  cfg_match_byte_r;
  logic [7:0]  cfg_match_offset_r;
  logic [15:0] cfg_min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_prefix_r       <= fspf_pkg::RST_BLOCK_PREFIX;
      cfg_match_byte_r   <= fspf_pkg::RST_MATCH_BYTE;
      cfg_match_offset_r <= fspf_pkg::RST_MATCH_OFFSET;
      cfg_min_len_r      <= fspf_pkg::RST_MIN_PAYLOAD_LEN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fspf_pkg::CFG_BLOCK_PREFIX:    cfg_prefix_r       <= cfg_wdata;
        fspf_pkg::CFG_MATCH_BYTE:      cfg_match_byte_r   <= cfg_wdata[7:0];
        fspf_pkg::CFG_MATCH_OFFSET:    cfg_match_offset_r <= cfg_wdata[7:0];
        fspf_pkg::CFG_MIN_PAYLOAD_LEN: cfg_min_len_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: parser -> verdict stage -> counter stage -> output
  // ---------------------------------------------------------------------
  logic out_valid_r;
  logic d_valid_r;
  logic e_valid_r;
  logic out_ready;
  logic e_ready;
  logic e_move;
  logic d_ready;
  logic d_move;
  logic in_acc;
  logic d_load;

  assign out_ready = !out_valid_r || !out_stall;
  assign e_move    = e_valid_r && out_ready;
  assign e_ready   = !e_valid_r || out_ready;
  assign d_move    = d_valid_r && e_ready;
  assign d_ready   = !d_valid_r || e_ready;
  assign in_stall  = !d_ready;
  assign in_acc    = in_valid && !in_stall;
  assign d_load    = in_acc && in_last_byte;

  // ---------------------------------------------------------------------
  // Byte parser
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_r, cnt_inc;
  logic [4:0]       nh_r, nh_nxt;
  logic [1:0]       tags_r, tags_nxt;
  logic [7:0]       etype_hi_r, etype_hi_nxt;
  logic [15:0]      etype_r, etype_nxt;
  logic [3:0]       ihl_r, ihl_nxt;
  logic [3:0]       doff_r, doff_nxt;
  logic [15:0]      tot_r, tot_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [23:0]      prefix_r, prefix_nxt;
  logic [7:0]       v6_next_r, v6_next_nxt;
  logic             pay_seen_r, pay_seen_nxt;
  logic             pay_hit_r, pay_hit_nxt;
  logic [7:0]       tcpb_r [fspf_pkg::TCP_EARLY_BYTES];

  logic [POS_W-1:0] pos, nh_pos, rel, ihl4, trel, t_late;
  logic [15:0]      new_etype;
  logic             past_eth, in_tcp, tcpb_wr;
  logic [3:0]       ihl_eff;
  logic [8:0]       t_early;

  always_comb begin
    cnt_inc      = (cnt_r < MAX_CNT) ? cnt_r + CNT_W'(1) : cnt_r;
    pos          = POS_W'(cnt_r);
    nh_pos       = POS_W'(nh_r);
    rel          = pos - nh_pos;
    past_eth     = (pos >= nh_pos);
    ihl_eff      = (past_eth && rel == fspf_pkg::IP_OFF_VER_IHL) ?
                   in_data_byte[3:0] : ihl_r;
    ihl4         = POS_W'({ihl_eff, 2'b00});
    in_tcp       = past_eth && (rel >= ihl4);
    trel         = rel - ihl4;
    tcpb_wr      = in_tcp && (trel < POS_W'(fspf_pkg::TCP_EARLY_BYTES));
    t_early      = 9'({in_data_byte[7:4], 2'b00}) + 9'(cfg_match_offset_r);
    t_late       = POS_W'({doff_r, 2'b00}) + POS_W'(cfg_match_offset_r);
    new_etype    = {etype_hi_r, in_data_byte};

    nh_nxt       = nh_r;
    tags_nxt     = tags_r;
    etype_hi_nxt = etype_hi_r;
    etype_nxt    = etype_r;
    ihl_nxt      = ihl_r;
    doff_nxt     = doff_r;
    tot_nxt      = tot_r;
    proto_nxt    = proto_r;
    prefix_nxt   = prefix_r;
    v6_next_nxt  = v6_next_r;
    pay_seen_nxt = pay_seen_r;
    pay_hit_nxt  = pay_hit_r;

    // Ethertype, with up to two VLAN tags pushing the network header back.
    if (pos == nh_pos - POS_W'(2)) begin
      etype_hi_nxt = in_data_byte;
    end
    if (pos == nh_pos - POS_W'(1)) begin
      etype_nxt = new_etype;
      if ((new_etype == fspf_pkg::ETYPE_VLAN_C || new_etype == fspf_pkg::ETYPE_VLAN_S)
          && tags_r < fspf_pkg::MAX_VLAN_TAGS) begin
        nh_nxt   = nh_r + fspf_pkg::VLAN_TAG_LEN;
        tags_nxt = tags_r + 2'd1;
      end
    end

    // IPv4 and IPv6 header fields at fixed offsets from the network header.
    if (past_eth) begin
      if (rel == fspf_pkg::IP_OFF_VER_IHL) ihl_nxt = in_data_byte[3:0];
      if (rel == fspf_pkg::IP_OFF_TLEN_HI) tot_nxt[15:8] = in_data_byte;
      if (rel == fspf_pkg::IP_OFF_TLEN_LO) tot_nxt[7:0] = in_data_byte;
      if (rel == fspf_pkg::IP6_OFF_NEXT)   v6_next_nxt = in_data_byte;
      if (rel == fspf_pkg::IP_OFF_PROTO)   proto_nxt = in_data_byte;
      if (rel == fspf_pkg::IP_OFF_DST0)    prefix_nxt[7:0] = in_data_byte;
      if (rel == fspf_pkg::IP_OFF_DST1)    prefix_nxt[15:8] = in_data_byte;
      if (rel == fspf_pkg::IP_OFF_DST2)    prefix_nxt[23:16] = in_data_byte;
    end

    // Payload probe byte. When it lies inside the first TCP header bytes it
    // is taken from the kept copy once the data offset is known; otherwise
    // it is caught as it streams past.
    if (in_tcp && trel == fspf_pkg::TCP_OFF_DOFF) begin
      doff_nxt = in_data_byte[7:4];
      if (t_early < 9'(fspf_pkg::TCP_EARLY_BYTES)) begin
        pay_seen_nxt = 1'b1;
        pay_hit_nxt  = (tcpb_r[t_early[EIW-1:0]] == cfg_match_byte_r);
      end else if (t_early == 9'(fspf_pkg::TCP_OFF_DOFF)) begin
        pay_seen_nxt = 1'b1;
        pay_hit_nxt  = (in_data_byte == cfg_match_byte_r);
      end
    end else if (in_tcp && trel > fspf_pkg::TCP_OFF_DOFF && trel == t_late) begin
      pay_seen_nxt = 1'b1;
      pay_hit_nxt  = (in_data_byte == cfg_match_byte_r);
    end
  end

  // Parser control state; cleared at reset and at the end of every frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      nh_r       <= fspf_pkg::ETH_HDR_LEN;
      tags_r     <= '0;
      pay_seen_r <= 1'b0;
    end else if (in_acc) begin
      if (in_last_byte) begin
        cnt_r      <= '0;
        nh_r       <= fspf_pkg::ETH_HDR_LEN;
        tags_r     <= '0;
        pay_seen_r <= 1'b0;
      end else begin
        cnt_r      <= cnt_inc;
        nh_r       <= nh_nxt;
        tags_r     <= tags_nxt;
        pay_seen_r <= pay_seen_nxt;
      end
    end
  end

  // Parser field registers; only read once the frame has reached them.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      etype_hi_r <= etype_hi_nxt;
      etype_r    <= etype_nxt;
      ihl_r      <= ihl_nxt;
      doff_r     <= doff_nxt;
      tot_r      <= tot_nxt;
      proto_r    <= proto_nxt;
      prefix_r   <= prefix_nxt;
      v6_next_r  <= v6_next_nxt;
      pay_hit_r  <= pay_hit_nxt;
      if (tcpb_wr) begin
        tcpb_r[trel[EIW-1:0]] <= in_data_byte;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Verdict stage: snapshot of the finished frame
  // ---------------------------------------------------------------------
  fspf_pkg::frm_info_t d_info_r;
  fspf_pkg::frm_info_t info_nxt;

  always_comb begin
    info_nxt.len      = POS_W'(cnt_inc);
    info_nxt.nh       = nh_nxt;
    info_nxt.etype    = etype_nxt;
    info_nxt.ihl      = ihl_nxt;
    info_nxt.doff     = doff_nxt;
    info_nxt.tot_len  = tot_nxt;
    info_nxt.proto    = proto_nxt;
    info_nxt.prefix   = prefix_nxt;
    info_nxt.v6_next  = v6_next_nxt;
    info_nxt.pay_seen = pay_seen_nxt;
    info_nxt.pay_hit  = pay_hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_load) begin
      d_valid_r <= 1'b1;
    end else if (d_move) begin
      d_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      d_info_r <= info_nxt;
    end
  end

  logic [POS_W-1:0] d_nh, d_ihl4, d_doff4, d_tcp_end, d_plen;
  logic             dec_verdict, dec_counted;
  logic [7:0]       dec_idx;
  logic [IDX_W-1:0] d_idx;

  // Pass/drop decision in the order the headers were parsed.
  always_comb begin
    d_nh        = POS_W'(d_info_r.nh);
    d_ihl4      = POS_W'({d_info_r.ihl, 2'b00});
    d_doff4     = POS_W'({d_info_r.doff, 2'b00});
    d_tcp_end   = d_nh + d_ihl4 + fspf_pkg::TCP_HDR_LEN;
    d_plen      = d_info_r.tot_len - d_ihl4 - d_doff4;
    dec_verdict = 1'b0;
    dec_counted = 1'b0;
    dec_idx     = 8'd0;
    if (d_info_r.len < d_nh) begin
      dec_verdict = 1'b1;
    end else if (d_info_r.etype == fspf_pkg::ETYPE_IPV4) begin
      if (d_info_r.len < d_nh + fspf_pkg::IPV4_HDR_LEN) begin
        dec_verdict = 1'b1;
      end else if (d_info_r.proto == fspf_pkg::IPPROTO_TCP &&
                   d_info_r.prefix == cfg_prefix_r) begin
        if (d_info_r.len < d_tcp_end) begin
          dec_verdict = 1'b1;
        end else if (d_plen < cfg_min_len_r) begin
          dec_verdict = 1'b1;
        end else if (d_info_r.pay_seen && d_info_r.pay_hit) begin
          dec_verdict = 1'b1;
          dec_counted = 1'b1;
          dec_idx     = d_info_r.proto;
        end
      end
    end else if (d_info_r.etype == fspf_pkg::ETYPE_IPV6) begin
      dec_verdict = 1'b1;
      if (d_info_r.len >= d_nh + fspf_pkg::IPV6_HDR_LEN) begin
        dec_counted = 1'b1;
        dec_idx     = d_info_r.v6_next;
      end
    end
    d_idx = IDX_W'(dec_idx);
  end

  // ---------------------------------------------------------------------
  // Counter stage: read-modify-write of the drop counter memory
  // ---------------------------------------------------------------------
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [COUNT_WIDTH-1:0]     ram_wdata;
  logic [COUNT_WIDTH-1:0]     ram_rdata;
  logic [COUNTER_ENTRIES-1:0] cnt_vld_r;

  logic                   e_verdict_r, e_counted_r, e_vbit_r, e_fwd_hit_r;
  logic [IDX_W-1:0]       e_idx_r;
  logic [COUNT_WIDTH-1:0] e_fwd_val_r;
  logic [COUNT_WIDTH-1:0] e_cur, e_inc;
  logic [EXT_W-1:0]       e_ext;

  fspf_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (COUNTER_ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (d_move),
    .raddr (d_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (d_move) begin
      e_valid_r <= 1'b1;
    end else if (e_move) begin
      e_valid_r <= 1'b0;
    end
  end

  // A write in the same cycle as the read is forwarded; the memory returns
  // the old value in that case. Unwritten counters read as zero.
  always_ff @(posedge clk) begin
    if (d_move) begin
      e_verdict_r <= dec_verdict;
      e_counted_r <= dec_counted;
      e_idx_r     <= d_idx;
      e_vbit_r    <= cnt_vld_r[d_idx];
      e_fwd_hit_r <= ram_we && (ram_waddr == d_idx);
      e_fwd_val_r <= ram_wdata;
    end
  end

  always_comb begin
    if (e_fwd_hit_r) begin
      e_cur = e_fwd_val_r;
    end else if (e_vbit_r) begin
      e_cur = ram_rdata;
    end else begin
      e_cur = '0;
    end
    e_inc     = (e_cur == '1) ? e_cur : e_cur + COUNT_WIDTH'(1);
    e_ext     = EXT_W'(e_inc);
    ram_we    = e_move && e_counted_r;
    ram_waddr = e_idx_r;
    ram_wdata = e_inc;
  end

  // Per-entry valid bits give the cleared state right after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (ram_we) begin
      cnt_vld_r[ram_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic        out_verdict_r, out_counted_r;
  logic [7:0]  out_index_r;
  logic [31:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (e_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_move) begin
      out_verdict_r <= e_verdict_r;
      out_counted_r <= e_counted_r;
      out_index_r   <= e_counted_r ? 8'(e_idx_r) : 8'd0;
      out_value_r   <= e_counted_r ? e_ext[fspf_pkg::OUT_VALUE_W-1:0] : 32'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_verdict_r;
  assign out_counted       = out_counted_r;
  assign out_counter_index = out_index_r;
  assign out_counter_value = out_value_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Counter memory is only written for a counted frame leaving the stage.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (e_valid_r && e_counted_r && out_ready))
    else $error("counter write without a counted frame");

  // A saturating increment never writes zero back.
  a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_wdata != '0))
    else $error("counter write of zero");

  // The parser restarts at position zero after the final byte of a frame.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    d_load |=> (cnt_r == '0 && pay_seen_r == 1'b0 && d_valid_r))
    else $error("parser did not restart after frame end");

  // A counter stage entry that cannot leave keeps its counter index.
  a_e_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && !out_ready) |=> (e_valid_r && $stable(e_idx_r)))
    else $error("counter stage lost a held frame");

endmodule

// File: tb/tb_top.sv
// Testbench for frame_subnet_payload_filter_top: builds Ethernet, VLAN, IPv4 and IPv6
// frames, predicts the verdict of each frame and checks every result item against it.
// Depends on fspf_pkg and the filter RTL; needs no other file.
module tb_top;
  import fspf_pkg::*;

  // One expected verdict item.
  typedef struct {
    bit        verdict;
    bit        counted;
    bit [7:0]  index;
    bit [31:0] value;
  } frame_verdict_t;

  // Mirrors the filter: register copies, the current frame's header bytes, the drop
  // counters and the verdicts still owed by the block.
  class verdict_tracker;
    bit [23:0]      prefix;
    bit [7:0]       mbyte;
    bit [7:0]       moffset;
    bit [15:0]      min_len;
    bit [7:0]       hdr [512];
    int unsigned    frame_len;
    bit [31:0]      drop_counts [256];
    frame_verdict_t expected_verdicts [$];
    int             errors;

    function new();
      prefix    = RST_BLOCK_PREFIX;
      mbyte     = RST_MATCH_BYTE;
      moffset   = RST_MATCH_OFFSET;
      min_len   = RST_MIN_PAYLOAD_LEN;
      frame_len = 0;
      errors    = 0;
      foreach (hdr[i]) hdr[i] = 8'd0;
      foreach (drop_counts[i]) drop_counts[i] = 32'd0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        CFG_BLOCK_PREFIX:    prefix  = data;
        CFG_MATCH_BYTE:      mbyte   = data[7:0];
        CFG_MATCH_OFFSET:    moffset = data[7:0];
        CFG_MIN_PAYLOAD_LEN: min_len = data[15:0];
        default: ;
      endcase
    endfunction

    // Saturating increment of one drop counter.
    function frame_verdict_t count_drop(bit [7:0] idx);
      frame_verdict_t v;
      if (drop_counts[idx] != 32'hFFFF_FFFF) drop_counts[idx]++;
      v.verdict = 1'b1;
      v.counted = 1'b1;
      v.index   = idx;
      v.value   = drop_counts[idx];
      return v;
    endfunction

    // Verdict of a finished frame of len bytes, from the kept header bytes.
    function frame_verdict_t judge_frame(int unsigned len);
      frame_verdict_t pass_v, plain_v;
      int unsigned nh, etype, ihl4, tcp, doff4, tot, plen, pay;
      bit [23:0] dst;
      pass_v  = '{1'b0, 1'b0, 8'd0, 32'd0};
      plain_v = '{1'b1, 1'b0, 8'd0, 32'd0};
      nh = 14;
      if (len < 14) return plain_v;
      etype = {hdr[12], hdr[13]};
      // Up to two VLAN tags shift the network header.
      repeat (2) begin
        if (etype == ETYPE_VLAN_C || etype == ETYPE_VLAN_S) begin
          nh += 4;
          if (len < nh) return plain_v;
          etype = {hdr[nh-2], hdr[nh-1]};
        end
      end
      if (etype == ETYPE_IPV4) begin
        if (len < nh + 20) return plain_v;
        dst = {hdr[nh+18], hdr[nh+17], hdr[nh+16]};
        if (hdr[nh+9] == IPPROTO_TCP && dst == prefix) begin
          ihl4 = 4 * hdr[nh][3:0];
          tcp  = nh + ihl4;
          if (len < tcp + 20) return plain_v;
          doff4 = 4 * hdr[tcp+12][7:4];
          tot   = {hdr[nh+2], hdr[nh+3]};
          plen  = (tot - ihl4 - doff4) & 32'hFFFF;
          if (plen < min_len) return plain_v;
          pay = tcp + doff4 + moffset;
          if (len < pay + 1) return pass_v;
          if (hdr[pay] == mbyte) return count_drop(IPPROTO_TCP);
        end
        return pass_v;
      end
      if (etype == ETYPE_IPV6) begin
        if (len < nh + 40) return plain_v;
        return count_drop(hdr[nh+6]);
      end
      return pass_v;
    endfunction

    // Called for every accepted input item.
    function void take_byte(bit [7:0] data, bit last);
      if (frame_len < 512) hdr[frame_len] = data;
      if (frame_len < DEF_MAX_FRAME_BYTES) frame_len++;
      if (last) begin
        expected_verdicts.push_back(judge_frame(frame_len));
        frame_len = 0;
        foreach (hdr[i]) hdr[i] = 8'd0;
      end
    endfunction

    // Called for every accepted result item.
    function void match_verdict(logic verdict, logic counted, logic [7:0] index,
                                logic [31:0] value);
      frame_verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result item: verdict %0d counted %0d index %0d value %0d",
               verdict, counted, index, value);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (verdict !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
        errors++;
      end
      if (counted !== want.counted) begin
        $error("counted: expected %0d, actual %0d", want.counted, counted);
        errors++;
      end
      if (index !== want.index) begin
        $error("counter_index: expected %0d, actual %0d", want.index, index);
        errors++;
      end
      if (value !== want.value) begin
        $error("counter_value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_verdict;
  logic        out_counted;
  logic [7:0]  out_counter_index;
  logic [31:0] out_counter_value;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_BLOCK_PREFIX;
  logic [23:0] cfg_wdata = 24'd0;

  verdict_tracker book = new();
  bit [7:0]       frame_buf [$];
  bit             tx_mode = 1'b1;
  bit             rx_mode = 1'b1;
  bit             hold_request = 1'b0;

  frame_subnet_payload_filter_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict       (out_verdict),
    .out_counted       (out_counted),
    .out_counter_index (out_counter_index),
    .out_counter_value (out_counter_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: checks each accepted item and stalls at random, or for a long stretch
  // when the stimulus asks for one.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        book.match_verdict(out_verdict, out_counted, out_counter_index, out_counter_value);
        stall_left = rx_mode ? $urandom_range(0, 5) : 0;
        if ($urandom_range(0, 15) == 0) rx_mode = ~rx_mode;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_request) begin
        stall_left   = 80;
        hold_request = 1'b0;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Offers one byte, after a random gap in tx_mode, and returns at the accepting edge.
  task automatic send_byte(bit [7:0] data, bit last);
    int gap;
    gap = tx_mode ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    book.take_byte(data, last);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Stops offering and waits until every owed verdict has come, plus the latency.
  task automatic drain();
    in_valid <= 1'b0;
    while (book.expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    book.set_reg(idx, data);
  endtask

  task automatic program_regs(bit [23:0] pfx, bit [7:0] mb, bit [7:0] mo, bit [15:0] ml);
    write_reg(CFG_BLOCK_PREFIX, pfx);
    write_reg(CFG_MATCH_BYTE, {16'd0, mb});
    write_reg(CFG_MATCH_OFFSET, {16'd0, mo});
    write_reg(CFG_MIN_PAYLOAD_LEN, {8'd0, ml});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void put(int pos, bit [7:0] val);
    if (pos < frame_buf.size()) frame_buf[pos] = val;
  endfunction

  // Fills frame_buf with a random frame and patches the header fields in place.
  // A positive cut gives the exact length, zero the full length, a negative cut a
  // random truncation.
  function automatic void build(int vlans, bit [15:0] etype, bit [3:0] ihl, bit [3:0] doff,
                                bit [7:0] proto, bit [23:0] dst, bit [15:0] plen, bit hit,
                                int cut);
    int nh, tcp, pay, full_len, total;
    bit [15:0] tpid, tot;
    nh  = 14 + 4 * vlans;
    tcp = nh + 4 * ihl;
    pay = tcp + 4 * doff + book.moffset;
    if (etype == ETYPE_IPV4) begin
      full_len = nh + 20;
      if (tcp + 20 > full_len) full_len = tcp + 20;
      if (pay + 1 > full_len) full_len = pay + 1;
    end else if (etype == ETYPE_IPV6) begin
      full_len = nh + 40;
    end else begin
      full_len = nh;
    end
    full_len += $urandom_range(0, 6);
    total = (cut > 0) ? cut : ((cut < 0) ? $urandom_range(1, full_len - 1) : full_len);
    frame_buf.delete();
    repeat (total) frame_buf.push_back(8'($urandom));
    for (int k = 0; k < vlans; k++) begin
      tpid = $urandom_range(0, 1) ? ETYPE_VLAN_C : ETYPE_VLAN_S;
      put(12 + 4 * k, tpid[15:8]);
      put(13 + 4 * k, tpid[7:0]);
    end
    put(nh - 2, etype[15:8]);
    put(nh - 1, etype[7:0]);
    if (etype == ETYPE_IPV4) begin
      tot = plen + 4 * ihl + 4 * doff;
      put(nh, {4'h4, ihl});
      put(nh + 2, tot[15:8]);
      put(nh + 3, tot[7:0]);
      put(nh + 9, proto);
      put(nh + 16, dst[7:0]);
      put(nh + 17, dst[15:8]);
      put(nh + 18, dst[23:16]);
      put(tcp + 12, {doff, 4'($urandom)});
      put(pay, hit ? book.mbyte : book.mbyte ^ 8'($urandom_range(1, 255)));
    end else if (etype == ETYPE_IPV6) begin
      put(nh, {4'h6, 4'($urandom)});
      put(nh + 6, proto);
    end
  endfunction

  // Mostly well-formed inspected TCP frames, plus near misses, IPv6 and noise.
  function automatic void random_frame();
    int kind, vlans, cut;
    bit [3:0] ihl, doff;
    bit [7:0] proto;
    bit [23:0] dst;
    bit [15:0] etype, plen;
    kind  = $urandom_range(0, 99);
    vlans = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2);
    ihl   = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
    doff  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
    proto = IPPROTO_TCP;
    dst   = book.prefix;
    etype = ETYPE_IPV4;
    case ($urandom_range(0, 3))
      0: plen = book.min_len + 16'($urandom_range(0, 30));
      1: plen = book.min_len - 16'd1 - 16'($urandom_range(0, 2));
      2: plen = book.min_len;
      default: plen = 16'($urandom);
    endcase
    cut = ($urandom_range(0, 6) == 0) ? -1 : 0;
    if (kind >= 55 && kind < 63) begin
      dst ^= 24'd1 << $urandom_range(0, 23);
    end else if (kind >= 63 && kind < 70) begin
      proto = 8'($urandom);
    end else if (kind >= 70 && kind < 82) begin
      etype = ETYPE_IPV6;
      proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    end else if (kind >= 82 && kind < 92) begin
      etype = 16'($urandom);
    end else if (kind >= 92) begin
      etype = 16'($urandom);
      cut   = $urandom_range(1, 40);
    end
    build(vlans, etype, ihl, doff, proto, dst, plen, $urandom_range(0, 1), cut);
  endfunction

  task automatic random_phase(int byte_goal, int frame_goal);
    int bytes_sent, frames_sent;
    bytes_sent  = 0;
    frames_sent = 0;
    while (bytes_sent < byte_goal || frames_sent < frame_goal) begin
      if ($urandom_range(0, 5) == 0) tx_mode = ~tx_mode;
      random_frame();
      bytes_sent += frame_buf.size();
      frames_sent++;
      send_frame();
    end
  endtask

  initial begin
    bit [23:0] pfx;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pfx = book.prefix;

    // Frames cut inside the Ethernet header or a VLAN tag, and a bare non-IP header.
    build(0, 16'hFFFF, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 1);   send_frame();
    build(0, 16'hFFFF, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 13);  send_frame();
    build(1, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 17); send_frame();
    build(0, 16'h0000, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 14);  send_frame();
    // A hit behind two stacked tags.
    build(2, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 0);  send_frame();
    // Truncated IPv4 header and truncated TCP header.
    build(0, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 33); send_frame();
    build(0, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 53); send_frame();
    // Payload one short of the minimum, then exactly at it.
    build(0, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, book.min_len - 16'd1, 1'b1, 0);
    send_frame();
    build(0, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, book.min_len, 1'b1, 0);
    send_frame();
    // Frame ends right before the compared byte, then a present but different byte.
    build(0, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 55); send_frame();
    build(0, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b0, 0);  send_frame();
    // Odd header lengths: IHL zero, IHL and data offset at maximum, data offset zero.
    build(0, ETYPE_IPV4, 4'd0, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 0);  send_frame();
    build(0, ETYPE_IPV4, 4'd15, 4'd15, IPPROTO_TCP, pfx, 16'd20, 1'b1, 0); send_frame();
    build(0, ETYPE_IPV4, 4'd5, 4'd0, IPPROTO_TCP, pfx, 16'd20, 1'b1, 0);  send_frame();
    // Not TCP, and a destination outside the prefix.
    build(0, ETYPE_IPV4, 4'd5, 4'd5, 8'd17, pfx, 16'd20, 1'b1, 0);        send_frame();
    build(0, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx ^ 24'h800000, 16'd20, 1'b1, 0);
    send_frame();
    // IPv6: top and bottom counters, a truncated header, and the TCP counter shared.
    build(0, ETYPE_IPV6, 4'd5, 4'd5, 8'hFF, pfx, 16'd20, 1'b1, 0);        send_frame();
    build(0, ETYPE_IPV6, 4'd5, 4'd5, 8'h00, pfx, 16'd20, 1'b1, 53);       send_frame();
    build(2, ETYPE_IPV6, 4'd5, 4'd5, 8'h00, pfx, 16'd20, 1'b1, 0);        send_frame();
    build(1, ETYPE_IPV6, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 0);  send_frame();
    // A third tag is not parsed, so the frame passes.
    build(2, ETYPE_VLAN_C, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd20, 1'b1, 0); send_frame();
    // A hit frame longer than the byte counter can count.
    build(1, ETYPE_IPV4, 4'd5, 4'd5, IPPROTO_TCP, pfx, 16'd100, 1'b1, 16400);
    send_frame();

    // Hold the result side off while one-byte frames arrive back to back, so the
    // pipeline fills and the input stalls; then pause until all verdicts are in.
    hold_request = 1'b1;
    tx_mode = 1'b0;
    repeat (12) begin
      frame_buf.delete();
      frame_buf.push_back(8'($urandom));
      send_frame();
    end
    tx_mode = 1'b1;
    drain();

    // Random traffic under the reset settings, then under extreme and random settings.
    random_phase(350, 12);
    drain();
    program_regs(24'hFFFFFF, 8'hFF, 8'h00, 16'hFFFF);
    random_phase(350, 12);
    drain();
    program_regs(24'h000000, 8'h00, 8'hFF, 16'h0000);
    random_phase(350, 12);
    repeat (2) begin
      drain();
      program_regs(24'($urandom), 8'($urandom), 8'($urandom_range(0, 16)),
                   16'($urandom_range(0, 48)));
      random_phase(350, 12);
    end
    drain();
    repeat (4) @(posedge clk);

    if (book.errors == 0 && book.expected_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
